// ----- design/efws_pkg.sv -----
`default_nettype none

package efws_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int POS_W       = $clog2(MAX_WORKERS);
    localparam int ID_W        = POS_W;
    localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
    localparam int CH_W        = POS_W + 2;
    localparam int TIME_W      = 48;
    localparam int SUM_W       = TIME_W + 1;
    localparam int DUR_W       = 32;
    localparam int IDX_W       = 6;
    localparam int CFG_W       = 7;
    localparam int ENTRY_W     = TIME_W + ID_W;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    localparam logic [PADDR_W-1:0] REG_WORKER_COUNT = '0;

    typedef enum logic {
        ST_IDLE,
        ST_SIFT
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] free_time;
        logic [ID_W-1:0]   worker_id;
    } entry_t;

    function automatic logic entry_before(entry_t a, entry_t b);
        logic res;
        if (a.free_time != b.free_time)
        begin
            res = a.free_time < b.free_time;
        end
        else
        begin
            res = a.worker_id < b.worker_id;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/efws_ram.sv -----
`default_nettype none

module efws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

// ----- design/earliest_free_worker_scheduler.sv -----
// Earliest-free-worker scheduler. Each job_duration item is assigned to the worker that
// becomes free first (ties to the lower worker id); the result item carries that worker
// and its free time as start_time, and the worker's free time then advances by the
// duration, saturating at 2^48-1. The heap root sits in registers and the rest of the
// heap in a RAM with two registered read ports. After an item is accepted, the updated root
// sinks at most floor(log2(worker_count)) heap levels, and no new item is accepted
// until that sift is done; the sift loop reads both children, compares and writes back
// one heap level per cycle. The result waits in an output register; once the sift is done
// a new item is accepted when that register is empty or is being read in the same cycle.
// Writing worker_count (address 0) resets every worker to free at time 0 at once; no
// clearing pass is needed.
`default_nettype none

module earliest_free_worker_scheduler
    import efws_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,

    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire logic [DUR_W-1:0]   job_duration,

    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic      [IDX_W-1:0]   worker_index,
    output logic      [TIME_W-1:0]  start_time
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    entry_t                 root_reg, root_next;
    entry_t                 held_reg, held_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [MAX_WORKERS-1:0] valid_reg, valid_next;
    logic                   lc_in_reg, lc_in_next;
    logic                   rc_in_reg, rc_in_next;
    logic                   rd_valid_a_reg, rd_valid_a_next;
    logic                   rd_valid_b_reg, rd_valid_b_next;
    logic [POS_W-1:0]       rd_addr_a_reg, rd_addr_a_next;
    logic [POS_W-1:0]       rd_addr_b_reg, rd_addr_b_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       out_idx_reg, out_idx_next;
    logic [TIME_W-1:0]      out_time_reg, out_time_next;

    logic                   job_accept;
    logic                   cfg_write;
    logic                   sift_done;
    logic [31:0]            cfg_value;
    logic [31:0]            id_ext;
    logic [SUM_W-1:0]       sum;
    logic [POS_W-1:0]       base;
    logic [CH_W-1:0]        lc;
    logic [CH_W-1:0]        rc;
    logic [ENTRY_W-1:0]     mem_a;
    logic [ENTRY_W-1:0]     mem_b;
    entry_t                 ent_l;
    entry_t                 ent_r;
    entry_t                 cand;
    entry_t                 mover;
    entry_t                 wval;
    logic [POS_W-1:0]       mover_pos;
    logic                   take_l;
    logic                   take_r;
    logic                   moving;
    logic                   mem_we;

    assign job_accept = job_valid && job_ready;
    assign cfg_write  = psel && penable && pwrite && pready && (paddr == REG_WORKER_COUNT);
    assign pready     = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_WORKER_COUNT)
        begin
            prdata = PDATA_W'(count_reg);
        end
    end

    efws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WORKERS)
    ) u_heap_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (pos_reg),
        .wdata   (wval),
        .raddr_a (rd_addr_a_next),
        .rdata_a (mem_a),
        .raddr_b (rd_addr_b_next),
        .rdata_b (mem_b)
    );

    // untouched entries read as their reset value
    always_comb
    begin
        ent_l = mem_a;
        ent_r = mem_b;
        if (!rd_valid_a_reg)
        begin
            ent_l.free_time = '0;
            ent_l.worker_id = rd_addr_a_reg;
        end
        if (!rd_valid_b_reg)
        begin
            ent_r.free_time = '0;
            ent_r.worker_id = rd_addr_b_reg;
        end
    end

    always_comb
    begin
        take_l    = lc_in_reg && entry_before(ent_l, held_reg);
        cand      = take_l ? ent_l : held_reg;
        take_r    = rc_in_reg && entry_before(ent_r, cand);
        moving    = take_l || take_r;
        mover     = take_r ? ent_r : ent_l;
        mover_pos = take_r ? rd_addr_b_reg : rd_addr_a_reg;
        wval      = moving ? mover : held_reg;
        sift_done = (state_reg == ST_SIFT) && !moving;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_accept)
                begin
                    state_next = ST_SIFT;
                end
            end
            ST_SIFT:
            begin
                if (sift_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        mem_we    = 1'b0;
        base      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                job_ready = !out_valid_reg || result_ready;
            end
            ST_SIFT:
            begin
                mem_we = (pos_reg != '0);
                base   = mover_pos;
            end
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cfg_value       = 32'(pwdata[CFG_W-1:0]);
        id_ext          = 32'(root_reg.worker_id);
        sum             = {1'b0, root_reg.free_time} + SUM_W'(job_duration);
        lc              = {base, 1'b1} + CH_W'(0);
        rc              = lc + CH_W'(1);

        count_next      = count_reg;
        root_next       = root_reg;
        held_next       = held_reg;
        pos_next        = pos_reg;
        valid_next      = valid_reg;
        lc_in_next      = lc < CH_W'(count_reg);
        rc_in_next      = rc < CH_W'(count_reg);
        rd_addr_a_next  = lc[POS_W-1:0];
        rd_addr_b_next  = rc[POS_W-1:0];
        rd_valid_a_next = valid_reg[lc[POS_W-1:0]];
        rd_valid_b_next = valid_reg[rc[POS_W-1:0]];
        out_valid_next  = out_valid_reg && !result_ready;
        out_idx_next    = out_idx_reg;
        out_time_next   = out_time_reg;

        if (job_accept)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = id_ext[IDX_W-1:0];
            out_time_next  = root_reg.free_time;
            held_next.worker_id = root_reg.worker_id;
            held_next.free_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            pos_next       = '0;
        end

        if (state_reg == ST_SIFT)
        begin
            if (pos_reg == '0)
            begin
                root_next = wval;
            end
            else
            begin
                valid_next[pos_reg] = 1'b1;
            end
            if (moving)
            begin
                pos_next = mover_pos;
            end
        end

        if (cfg_write)
        begin
            if (cfg_value == 32'd0)
            begin
                cfg_value = 32'd1;
            end
            if (cfg_value > 32'(MAX_WORKERS))
            begin
                cfg_value = 32'(MAX_WORKERS);
            end
            count_next = cfg_value[CNT_W-1:0];
            valid_next = '0;
            root_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_W'(1);
            root_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            root_reg      <= root_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg       <= held_next;
        pos_reg        <= pos_next;
        lc_in_reg      <= lc_in_next;
        rc_in_reg      <= rc_in_next;
        rd_addr_a_reg  <= rd_addr_a_next;
        rd_addr_b_reg  <= rd_addr_b_next;
        rd_valid_a_reg <= rd_valid_a_next;
        rd_valid_b_reg <= rd_valid_b_next;
        out_idx_reg    <= out_idx_next;
        out_time_reg   <= out_time_next;
    end

    assign result_valid = out_valid_reg;
    assign worker_index = out_idx_reg;
    assign start_time   = out_time_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        job_accept |=> (state_reg == ST_SIFT) && out_valid_reg)
        else $error("accepted item did not start a sift");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT) |-> !job_ready)
        else $error("item accepted during sift");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT) |-> (CNT_W'(pos_reg) < count_reg))
        else $error("sift position beyond worker count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_WORKERS)))
        else $error("worker count out of range");

endmodule

`default_nettype wire

// ----- sim/tb_earliest_free_worker_scheduler.sv -----
`timescale 1ns / 1ps

module tb_earliest_free_worker_scheduler;
    import efws_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int PEAK_ITEMS    = 6;
    localparam int PHASE_ITEMS   = 160;
    localparam int NUM_PHASES    = 12;
    localparam int NUM_ROWS      = 25;

    typedef struct packed {
        logic [IDX_W-1:0]  worker;
        logic [TIME_W-1:0] start;
    } job_assignment_t;

    typedef enum logic {
        ROW_JOB,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [31:0]       value;
        logic              has_exp;
        logic [IDX_W-1:0]  worker;
        logic [TIME_W-1:0] start;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               job_valid;
    logic               job_ready;
    logic [DUR_W-1:0]   job_duration;

    logic               result_valid;
    logic               result_ready;
    logic [IDX_W-1:0]   worker_index;
    logic [TIME_W-1:0]  start_time;

    earliest_free_worker_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job_duration (job_duration),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .worker_index (worker_index),
        .start_time   (start_time)
    );

    always #1 clk = ~clk;

    logic [TIME_W-1:0] free_at     [MAX_WORKERS];
    logic [IDX_W-1:0]  heap_worker [MAX_WORKERS];
    int                active_workers;

    job_assignment_t pending_assignments [$];
    int              mismatch_count = 0;

    bit sender_idle_on = 1'b1;
    bit rx_free        = 1'b0;
    bit hold_request   = 1'b0;
    int burst_left     = 0;

    dir_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{ROW_JOB, 32'd5,          1'b1, 6'd0, 48'd0},
        '{ROW_JOB, 32'hFFFF_FFFF,  1'b1, 6'd0, 48'd5},
        '{ROW_JOB, 32'd0,          1'b1, 6'd0, 48'h1_0000_0004},
        '{ROW_CFG, 32'd4,          1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'd10,         1'b1, 6'd0, 48'd0},
        '{ROW_JOB, 32'd0,          1'b1, 6'd1, 48'd0},
        '{ROW_JOB, 32'd0,          1'b1, 6'd1, 48'd0},
        '{ROW_JOB, 32'd3,          1'b1, 6'd1, 48'd0},
        '{ROW_JOB, 32'd1,          1'b1, 6'd2, 48'd0},
        '{ROW_JOB, 32'd2,          1'b0, 6'd0, 48'd0},
        '{ROW_CFG, 32'd0,          1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'd7,          1'b1, 6'd0, 48'd0},
        '{ROW_JOB, 32'd7,          1'b1, 6'd0, 48'd7},
        '{ROW_CFG, 32'd127,        1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'hFFFF_FFFF,  1'b1, 6'd0, 48'd0},
        '{ROW_JOB, 32'd1,          1'b1, 6'd1, 48'd0},
        '{ROW_JOB, 32'd0,          1'b0, 6'd0, 48'd0},
        '{ROW_CFG, 32'd65,         1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'd2,          1'b1, 6'd0, 48'd0},
        '{ROW_JOB, 32'd2,          1'b1, 6'd1, 48'd0},
        '{ROW_CFG, 32'd2,          1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'hFFFF_FFFF,  1'b1, 6'd0, 48'd0},
        '{ROW_JOB, 32'd1,          1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'd1,          1'b0, 6'd0, 48'd0},
        '{ROW_JOB, 32'd0,          1'b0, 6'd0, 48'd0}
    };

    logic [31:0] phase_counts [0:NUM_PHASES-1] = '{
        32'd64, 32'd2, 32'h0000_007F, 32'd7, 32'hFFFF_FF80, 32'd33,
        32'd65, 32'd5, 32'hABCD_EF8A, 32'd64, 32'd0, 32'd3
    };

    function automatic bit outranks(input int a, input int b);
        if (free_at[a] != free_at[b])
        begin
            return free_at[a] < free_at[b];
        end
        return heap_worker[a] < heap_worker[b];
    endfunction

    function automatic void restart_heap();
        for (int k = 0; k < MAX_WORKERS; k++)
        begin
            free_at[k]     = '0;
            heap_worker[k] = k[IDX_W-1:0];
        end
    endfunction

    function automatic void load_worker_count(input logic [PDATA_W-1:0] value);
        int v;
        v = int'(value[CFG_W-1:0]);
        if (v < 1)
        begin
            v = 1;
        end
        if (v > MAX_WORKERS)
        begin
            v = MAX_WORKERS;
        end
        active_workers = v;
        restart_heap();
    endfunction

    function automatic job_assignment_t predict_assignment(input logic [DUR_W-1:0] dur);
        job_assignment_t   res;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] t_swap;
        logic [IDX_W-1:0]  w_swap;
        int                pos;
        int                best;
        int                lc;
        int                rc;
        bit                settled;
        res.worker = heap_worker[0];
        res.start  = free_at[0];
        sum = {1'b0, free_at[0]} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
        free_at[0] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        pos = 0;
        settled = 1'b0;
        while (!settled)
        begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < active_workers && outranks(lc, best))
            begin
                best = lc;
            end
            if (rc < active_workers && outranks(rc, best))
            begin
                best = rc;
            end
            if (best == pos)
            begin
                settled = 1'b1;
            end
            else
            begin
                t_swap            = free_at[pos];
                w_swap            = heap_worker[pos];
                free_at[pos]      = free_at[best];
                heap_worker[pos]  = heap_worker[best];
                free_at[best]     = t_swap;
                heap_worker[best] = w_swap;
                pos = best;
            end
        end
        return res;
    endfunction

    function automatic logic [DUR_W-1:0] random_duration();
        logic [DUR_W-1:0] dur;
        case ($urandom_range(0, 9))
            0:       dur = '0;
            1:       dur = '1;
            2, 3, 4: dur = $urandom_range(0, 15);
            5, 6:    dur = $urandom_range(0, 1000);
            default: dur = $urandom();
        endcase
        return dur;
    endfunction

    // Leaves job_valid high after the handshake; the next call or wait_idle decides.
    task automatic send_job(input logic [DUR_W-1:0] dur, input bit use_exp,
                            input job_assignment_t typed_exp);
        job_assignment_t predicted;
        if (sender_idle_on)
        begin
            if (burst_left == 0)
            begin
                job_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        job_valid    <= 1'b1;
        job_duration <= dur;
        do @(posedge clk); while (!job_ready);
        predicted = predict_assignment(dur);
        if (use_exp)
        begin
            predicted = typed_exp;
        end
        pending_assignments = {pending_assignments, predicted};
    endtask

    task automatic wait_idle();
        job_valid <= 1'b0;
        while (pending_assignments.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_worker_count(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_WORKER_COUNT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        load_worker_count(value);
    endtask

    always @(posedge clk)
    begin : check_result
        job_assignment_t due;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_assignments.size() == 0)
            begin
                $error("unexpected item: worker_index %0d start_time %0d",
                       worker_index, start_time);
                mismatch_count++;
            end
            else
            begin
                due = pending_assignments.pop_front();
                if (worker_index !== due.worker)
                begin
                    $error("worker_index: expected %0d, actual %0d", due.worker, worker_index);
                    mismatch_count++;
                end
                if (start_time !== due.start)
                begin
                    $error("start_time: expected %0d, actual %0d", due.start, start_time);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int  run_left;
        bit  run_level;
        run_left  = 0;
        run_level = 1'b1;
        result_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (rx_free)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_level = ($urandom_range(0, 2) != 0);
                    run_left  = run_level ? $urandom_range(1, 30) : $urandom_range(1, 6);
                end
                result_ready <= run_level;
                run_left--;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        #4000000;
        $display("tb_earliest_free_worker_scheduler: done, errors");
        $finish;
    end

    initial
    begin
        job_assignment_t typed;
        logic [31:0]     count_value;
        rst_n        <= 1'b0;
        job_valid    <= 1'b0;
        job_duration <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        active_workers = 1;
        restart_heap();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_worker_count(directed_rows[r].value);
            end
            else
            begin
                typed.worker = directed_rows[r].worker;
                typed.start  = directed_rows[r].start;
                send_job(directed_rows[r].value, directed_rows[r].has_exp, typed);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            count_value = (p == 10) ? $urandom_range(1, MAX_WORKERS) : phase_counts[p];
            write_worker_count(count_value);
            sender_idle_on = (p % 3 != 2);
            // hold the result side so the block backs up into its input
            if (p == 3)
            begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_job(random_duration(), 1'b0, typed);
            end
        end

        // run one worker at full rate: maximum durations, then four random durations
        wait_idle();
        write_worker_count(32'd1);
        sender_idle_on = 1'b0;
        rx_free = 1'b1;
        for (int i = 0; i < PEAK_ITEMS; i++)
        begin
            send_job('1, 1'b0, typed);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_job(random_duration(), 1'b0, typed);
        end
        rx_free = 1'b0;

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("tb_earliest_free_worker_scheduler: done, clean");
        end
        else
        begin
            $display("tb_earliest_free_worker_scheduler: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/efws_pkg.sv
design/efws_ram.sv
design/earliest_free_worker_scheduler.sv
sim/tb_earliest_free_worker_scheduler.sv
